/* sv/sld_pkg.sv */
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants of the scan line decoder
// Line buffer sizing, command records passed from front to back, result
// record and the character decode helper.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int LINE_BYTES        = 128;
    localparam int MAX_SCAN_READINGS = 1024;

    localparam int LEN_W     = $clog2(LINE_BYTES);
    localparam int RC_W      = $clog2(MAX_SCAN_READINGS) + 1;
    localparam int RAM_AW    = LEN_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int Q_DEPTH   = 2;

    localparam int INDEX_W = 10;
    localparam int TIME_W  = 24;
    localparam int WRAP_W  = 16;
    localparam int VALUE_W = 18;
    localparam int ACC_W   = 2 * VALUE_W;

    localparam logic [7:0] CHAR_BIAS = 8'h30;
    localparam logic [7:0] LINE_FEED = 8'h0A;

    localparam logic [2:0] GROUP_RANGE = 3'd3;
    localparam logic [2:0] GROUP_BOTH  = 3'd6;

    localparam logic [1:0] ERR_TIME_SUM = 2'd0;
    localparam logic [1:0] ERR_DATA_SUM = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_LONG     = 2'd3;

    typedef enum logic [1:0] {
        RK_READING = 2'd0,
        RK_TIME    = 2'd1,
        RK_END     = 2'd2,
        RK_ERROR   = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TIME = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_SHIFT = 2'd2
    } back_state_t;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_TIME  = 3'd1,
        CMD_DATA  = 3'd2,
        CMD_END   = 3'd3,
        CMD_ERROR = 3'd4
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic               mode;
        logic [1:0]         err;
        logic [TIME_W-1:0]  stamp;
        logic [LEN_W-1:0]   n;
        logic               bank;
    } cmd_t;

    typedef struct packed {
        result_kind_t          kind;
        logic [VALUE_W-1:0]    range_mm;
        logic [VALUE_W-1:0]    intensity_value;
        logic [INDEX_W-1:0]    reading_index;
        logic [WRAP_W+TIME_W-1:0] time_ms;
        logic                  time_repeat;
        logic [1:0]            error_code;
        logic                  last;
    } result_t;

    // character value: (byte - 0x30) mod 64
    function automatic logic [5:0] char_value(input logic [7:0] b);
        char_value = b[5:0] - CHAR_BIAS[5:0];
    endfunction

endpackage

/* sv/sld_ram.sv */
// ----------------------------------------------------------------------------
// sld_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/sld_queue.sv */
// ----------------------------------------------------------------------------
// sld_queue: two-entry command queue
// Carries line commands from the front to the back; the head stays until
// the back has finished with it.
// ----------------------------------------------------------------------------
module sld_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sld_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sld_pkg::cmd_t head,
    output logic          not_empty,
    output logic          full
);

    sld_pkg::cmd_t mem_reg [sld_pkg::Q_DEPTH];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(sld_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/sld_front.sv */
// ----------------------------------------------------------------------------
// sld_front: byte intake and line classification
// Stores line bytes into the line buffer, keeps running checksums and the
// group position, and turns each line end into a command for the back.
// ----------------------------------------------------------------------------
module sld_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_kind,
    input  logic [7:0]                 in_byte,
    input  logic                       in_mode,
    input  logic                       q_full,
    output logic                       push,
    output sld_pkg::cmd_t              push_cmd,
    output logic                       ram_we,
    output logic [sld_pkg::RAM_AW-1:0] ram_waddr,
    output logic [7:0]                 ram_wdata
);

    localparam int LW = sld_pkg::LEN_W;

    sld_pkg::phase_t          phase_reg;
    sld_pkg::phase_t          phase_next;
    logic [LW-1:0]            len_reg;
    logic [LW-1:0]            len_next;
    logic [2:0]               carry_reg;
    logic [2:0]               carry_next;
    logic [2:0]               pos_reg;
    logic [2:0]               pos_next;
    logic [2:0]               pos_prev_reg;
    logic [2:0]               pos_prev_next;
    logic [5:0]               sum_reg;
    logic [5:0]               sum_next;
    logic [7:0]               last_reg;
    logic [7:0]               last_next;
    logic [sld_pkg::TIME_W-1:0] time_reg;
    logic [sld_pkg::TIME_W-1:0] time_next;
    logic                     mode_reg;
    logic                     mode_next;
    logic                     bank_reg;
    logic                     bank_next;

    logic                     accept;
    logic [2:0]               group_len;
    logic [2:0]               pos_inc;
    logic                     too_long;
    logic [5:0]               data_sum;
    logic                     data_ok;
    logic                     time_ok;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign ram_waddr = {bank_reg, len_reg};
    assign ram_wdata = in_byte;

    always_comb
    begin
        group_len = mode_reg ? sld_pkg::GROUP_BOTH : sld_pkg::GROUP_RANGE;
        pos_inc   = ((pos_reg + 3'd1) == group_len) ? 3'd0 : pos_reg + 3'd1;
        too_long  = (({1'b0, len_reg} + (LW+1)'(carry_reg))
                     >= (LW+1)'(sld_pkg::LINE_BYTES - 2));
        data_sum  = sum_reg - last_reg[5:0];
        data_ok   = (({2'b00, data_sum} + sld_pkg::CHAR_BIAS) == last_reg);
        time_ok   = (len_reg >= LW'(5))
                    && (({2'b00, sum_reg} + sld_pkg::CHAR_BIAS) == last_reg);

        phase_next    = phase_reg;
        len_next      = len_reg;
        carry_next    = carry_reg;
        pos_next      = pos_reg;
        pos_prev_next = pos_prev_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        time_next     = time_reg;
        mode_next     = mode_reg;
        bank_next     = bank_reg;
        push          = 1'b0;
        push_cmd      = '0;
        push_cmd.bank = bank_reg;
        ram_we        = 1'b0;

        if (accept)
        begin
            if (in_kind)
            begin
                mode_next     = in_mode;
                phase_next    = sld_pkg::PH_TIME;
                len_next      = '0;
                carry_next    = 3'd0;
                pos_next      = 3'd0;
                pos_prev_next = 3'd0;
                sum_next      = 6'd0;
                time_next     = '0;
                push          = 1'b1;
                push_cmd.op   = sld_pkg::CMD_START;
                push_cmd.mode = in_mode;
            end
            else if (phase_reg != sld_pkg::PH_IDLE)
            begin
                if (in_byte != sld_pkg::LINE_FEED)
                begin
                    if (too_long)
                    begin
                        push         = 1'b1;
                        push_cmd.op  = sld_pkg::CMD_ERROR;
                        push_cmd.err = sld_pkg::ERR_LONG;
                        phase_next   = sld_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        len_next = len_reg + LW'(1);
                        // timestamp line sums only its four time characters
                        if (phase_reg == sld_pkg::PH_DATA || len_reg < LW'(4))
                        begin
                            sum_next = sum_reg + in_byte[5:0];
                        end
                        if (phase_reg == sld_pkg::PH_DATA || len_reg == LW'(4))
                        begin
                            last_next = in_byte;
                        end
                        if (phase_reg == sld_pkg::PH_TIME && len_reg < LW'(4))
                        begin
                            time_next = {time_reg[sld_pkg::TIME_W-7:0],
                                         sld_pkg::char_value(in_byte)};
                        end
                        if (phase_reg == sld_pkg::PH_DATA)
                        begin
                            pos_prev_next = pos_reg;
                            pos_next      = pos_inc;
                        end
                    end
                end
                else if (phase_reg == sld_pkg::PH_TIME)
                begin
                    push      = 1'b1;
                    len_next  = '0;
                    sum_next  = 6'd0;
                    time_next = '0;
                    if (time_ok)
                    begin
                        push_cmd.op    = sld_pkg::CMD_TIME;
                        push_cmd.stamp = time_reg;
                        phase_next     = sld_pkg::PH_DATA;
                    end
                    else
                    begin
                        push_cmd.op  = sld_pkg::CMD_ERROR;
                        push_cmd.err = sld_pkg::ERR_TIME_SUM;
                        phase_next   = sld_pkg::PH_IDLE;
                    end
                end
                else
                begin
                    push = 1'b1;
                    priority if (len_reg == '0)
                    begin
                        push_cmd.op = sld_pkg::CMD_END;
                        phase_next  = sld_pkg::PH_IDLE;
                    end
                    else if (!data_ok)
                    begin
                        push_cmd.op  = sld_pkg::CMD_ERROR;
                        push_cmd.err = sld_pkg::ERR_DATA_SUM;
                        phase_next   = sld_pkg::PH_IDLE;
                    end
                    else
                    begin
                        // leftover characters become the carry of the next line
                        push_cmd.op = sld_pkg::CMD_DATA;
                        push_cmd.n  = len_reg - LW'(1);
                        bank_next   = ~bank_reg;
                        len_next    = '0;
                        sum_next    = 6'd0;
                        carry_next  = pos_prev_reg;
                        pos_next    = pos_prev_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= sld_pkg::PH_IDLE;
            len_reg      <= '0;
            carry_reg    <= 3'd0;
            pos_reg      <= 3'd0;
            pos_prev_reg <= 3'd0;
            sum_reg      <= 6'd0;
            last_reg     <= 8'd0;
            time_reg     <= '0;
            mode_reg     <= 1'b0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            carry_reg    <= carry_next;
            pos_reg      <= pos_next;
            pos_prev_reg <= pos_prev_next;
            sum_reg      <= sum_next;
            last_reg     <= last_next;
            time_reg     <= time_next;
            mode_reg     <= mode_next;
            bank_reg     <= bank_next;
        end
    end

endmodule

/* sv/sld_back.sv */
// ----------------------------------------------------------------------------
// sld_back: command execution and reading decode
// Runs the queued commands: timestamps with wrap tracking, scan end and
// error results, and the character walk over a stored line into readings.
// ----------------------------------------------------------------------------
module sld_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  sld_pkg::cmd_t              head,
    output logic                       pop,
    output logic                       ram_re,
    output logic [sld_pkg::RAM_AW-1:0] ram_raddr,
    input  logic [7:0]                 ram_rdata,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sld_pkg::result_t           out_result
);

    localparam int LW = sld_pkg::LEN_W;
    localparam int RW = sld_pkg::RC_W;
    localparam int VW = sld_pkg::VALUE_W;

    sld_pkg::back_state_t       state_reg;
    sld_pkg::back_state_t       state_next;
    logic                       mode_reg;
    logic                       mode_next;
    logic                       drop_reg;
    logic                       drop_next;
    logic [sld_pkg::ACC_W-1:0]  acc_reg;
    logic [sld_pkg::ACC_W-1:0]  acc_next;
    logic [2:0]                 cnt_reg;
    logic [2:0]                 cnt_next;
    logic [RW-1:0]              rc_reg;
    logic [RW-1:0]              rc_next;
    logic [LW-1:0]              idx_reg;
    logic [LW-1:0]              idx_next;
    logic [sld_pkg::TIME_W-1:0] prev_reg;
    logic [sld_pkg::TIME_W-1:0] prev_next;
    logic [sld_pkg::WRAP_W-1:0] wrap_reg;
    logic [sld_pkg::WRAP_W-1:0] wrap_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    sld_pkg::result_t           out_reg;
    sld_pkg::result_t           out_next;

    logic                       can_load;
    logic                       load;
    logic [2:0]                 group_len;
    logic [2:0]                 cnt_inc;
    logic                       group_done;
    logic                       line_end;
    logic [LW-1:0]              remaining;
    logic [sld_pkg::ACC_W-1:0]  acc_shift;
    logic [sld_pkg::WRAP_W-1:0] wrap_upd;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign can_load   = !out_valid_reg || out_ready;
    assign ram_raddr  = {head.bank, idx_reg};

    always_comb
    begin
        group_len  = mode_reg ? sld_pkg::GROUP_BOTH : sld_pkg::GROUP_RANGE;
        cnt_inc    = cnt_reg + 3'd1;
        group_done = (cnt_inc == group_len);
        line_end   = (idx_reg == head.n - LW'(1));
        remaining  = head.n - LW'(1) - idx_reg;
        acc_shift  = {acc_reg[sld_pkg::ACC_W-7:0], sld_pkg::char_value(ram_rdata)};
        wrap_upd   = (head.stamp < prev_reg) ? wrap_reg + sld_pkg::WRAP_W'(1) : wrap_reg;

        state_next = state_reg;
        mode_next  = mode_reg;
        drop_next  = drop_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rc_next    = rc_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        wrap_next  = wrap_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        load       = 1'b0;
        out_next   = out_reg;

        unique case (state_reg)
            sld_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (head.op)
                        sld_pkg::CMD_START:
                        begin
                            mode_next = head.mode;
                            cnt_next  = 3'd0;
                            rc_next   = '0;
                            drop_next = 1'b0;
                            pop       = 1'b1;
                        end
                        sld_pkg::CMD_DATA:
                        begin
                            if (drop_reg || head.n == '0)
                            begin
                                pop = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = sld_pkg::BK_READ;
                            end
                        end
                        sld_pkg::CMD_TIME:
                        begin
                            if (drop_reg)
                            begin
                                pop = 1'b1;
                            end
                            else if (can_load)
                            begin
                                load                 = 1'b1;
                                pop                  = 1'b1;
                                out_next             = '0;
                                out_next.last        = 1'b1;
                                out_next.kind        = sld_pkg::RK_TIME;
                                out_next.time_ms     = {wrap_upd, head.stamp};
                                out_next.time_repeat = (head.stamp == prev_reg);
                                wrap_next            = wrap_upd;
                                prev_next            = head.stamp;
                            end
                        end
                        sld_pkg::CMD_END:
                        begin
                            if (drop_reg)
                            begin
                                pop = 1'b1;
                            end
                            else if (can_load)
                            begin
                                load          = 1'b1;
                                pop           = 1'b1;
                                out_next      = '0;
                                out_next.last = 1'b1;
                                out_next.kind = sld_pkg::RK_END;
                            end
                        end
                        sld_pkg::CMD_ERROR:
                        begin
                            if (drop_reg)
                            begin
                                pop = 1'b1;
                            end
                            else if (can_load)
                            begin
                                load                = 1'b1;
                                pop                 = 1'b1;
                                out_next            = '0;
                                out_next.last       = 1'b1;
                                out_next.kind       = sld_pkg::RK_ERROR;
                                out_next.error_code = head.err;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end

            sld_pkg::BK_READ:
            begin
                ram_re     = 1'b1;
                state_next = sld_pkg::BK_SHIFT;
            end

            sld_pkg::BK_SHIFT:
            begin
                // hold the read data until the output register can take a reading
                if (!group_done || can_load)
                begin
                    if (group_done && rc_reg >= RW'(sld_pkg::MAX_SCAN_READINGS))
                    begin
                        load                = 1'b1;
                        out_next            = '0;
                        out_next.kind       = sld_pkg::RK_ERROR;
                        out_next.error_code = sld_pkg::ERR_OVERFLOW;
                        out_next.last       = 1'b1;
                        drop_next           = 1'b1;
                        pop                 = 1'b1;
                        state_next          = sld_pkg::BK_IDLE;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        cnt_next = group_done ? 3'd0 : cnt_inc;
                        if (group_done)
                        begin
                            load          = 1'b1;
                            out_next      = '0;
                            out_next.kind = sld_pkg::RK_READING;
                            out_next.range_mm = mode_reg ? acc_shift[2*VW-1:VW]
                                                         : acc_shift[VW-1:0];
                            out_next.intensity_value = mode_reg ? acc_shift[VW-1:0]
                                                                : '0;
                            out_next.reading_index = sld_pkg::INDEX_W'(rc_reg);
                            out_next.last = (remaining < LW'(group_len));
                            rc_next       = rc_reg + RW'(1);
                        end
                        if (line_end)
                        begin
                            pop        = 1'b1;
                            state_next = sld_pkg::BK_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + LW'(1);
                            state_next = sld_pkg::BK_READ;
                        end
                    end
                end
            end

            default:
            begin
                state_next = sld_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        acc_reg <= acc_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sld_pkg::BK_IDLE;
            mode_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            rc_reg        <= '0;
            prev_reg      <= '0;
            wrap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            drop_reg      <= drop_next;
            cnt_reg       <= cnt_next;
            rc_reg        <= rc_next;
            prev_reg      <= prev_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/scan_line_decoder.sv */
// ----------------------------------------------------------------------------
// scan_line_decoder: rangefinder data block decoder
// Front stores and checks each line, a two-entry queue hands line commands to
// the back, which emits timestamps, readings, scan ends and errors.
// ----------------------------------------------------------------------------
// Order: a line feed pushes the line's command into the queue; the back then
//   reads each stored data character (BK_READ) and shifts it in (BK_SHIFT).
// Throughput: one request per cycle while the queue has room; the back reads a
//   line one character at a time (one line buffer read port).
// Reset: control state clears at once; the line buffer holds no reset values.
module scan_line_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], with_intensity[8], zero pad
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // range_mm[17:0], intensity_value[35:18],
                                        // reading_index[45:36], time_ms[85:46],
                                        // time_repeat[86], error_code[88:87], zero pad
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last
);

    logic                       q_push;
    sld_pkg::cmd_t              q_push_cmd;
    logic                       q_pop;
    sld_pkg::cmd_t              q_head;
    logic                       q_not_empty;
    logic                       q_full;
    logic                       ram_we;
    logic [sld_pkg::RAM_AW-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       ram_re;
    logic [sld_pkg::RAM_AW-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;
    sld_pkg::result_t           result;

    sld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata[7:0]),
        .in_mode   (s_axis_tdata[8]),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    sld_ram #(
        .WIDTH (8),
        .DEPTH (sld_pkg::RAM_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    sld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .head       (q_head),
        .pop        (q_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {7'd0, result.error_code, result.time_repeat, result.time_ms,
                           result.reading_index, result.intensity_value,
                           result.range_mm};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

    // a full queue must hold off new requests
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready)
        else $error("request taken while command queue full");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("command queue overflow");

    // an error always closes the results of its request
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == sld_pkg::RK_ERROR) |-> m_axis_tlast)
        else $error("error result without last");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from empty command queue");

endmodule
